[rtl/kvs_pkg.sv]
// Shared types, codes and defaults for the key-value store.
`timescale 1ns / 1ps
package kvs_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REKEY  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_key;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } kv_word_t;

endpackage

[rtl/kvs_ram.sv]
// Simple dual-port synchronous RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module kvs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/kvs_seq.sv]
// Command sequencer: scans the recency list, rebuilds it in the spare bank and updates entries.
`timescale 1ns / 1ps
module kvs_seq #(
  parameter int CAPACITY = kvs_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  kvs_pkg::req_t               req,
  output logic                        idle,
  output logic                        done,
  input  logic                        take,
  output kvs_pkg::rsp_t               rsp,
  output logic                        ord_we,
  output logic [$clog2(CAPACITY):0]   ord_waddr,
  output logic [$clog2(CAPACITY)-1:0] ord_wdata,
  output logic [$clog2(CAPACITY):0]   ord_raddr,
  input  logic [$clog2(CAPACITY)-1:0] ord_rdata,
  output logic                        kv_we,
  output logic [$clog2(CAPACITY)-1:0] kv_waddr,
  output kvs_pkg::kv_word_t           kv_wdata,
  output logic [$clog2(CAPACITY)-1:0] kv_raddr,
  input  kvs_pkg::kv_word_t           kv_rdata
);

  import kvs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_DONE} state_t;

  state_t                   state_r;
  logic                     bank_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            rd_pos_r;
  logic                     v1_r;
  logic [AW-1:0]            pos1_r;
  logic                     v2_r;
  logic [AW-1:0]            pos2_r;
  logic [AW-1:0]            slot2_r;
  logic                     found_r;
  logic [AW-1:0]            hit_slot_r;
  logic signed [DATA_W-1:0] hit_val_r;
  req_t                     req_r;
  rsp_t                     rsp_r;

  logic match;
  logic full;
  logic issue;

  assign match = v2_r && !found_r && (kv_rdata.key == req_r.key);
  assign full  = (count_r == CW'(CAPACITY));
  assign issue = (rd_pos_r != count_r);

  assign ord_raddr = {bank_r, rd_pos_r[AW-1:0]};
  assign kv_raddr  = ord_rdata;

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign rsp  = rsp_r;

  // The rebuilt list goes to the spare bank: entries ahead of the match move down by one,
  // the match goes to the front and the rest keep their place.
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = {~bank_r, {AW{1'b0}}};
    ord_wdata = slot2_r;
    if (state_r == S_SCAN && v2_r) begin
      ord_we = 1'b1;
      if (found_r) begin
        ord_waddr = {~bank_r, pos2_r};
      end else if (!match) begin
        ord_waddr = {~bank_r, pos2_r + AW'(1)};
      end
    end else if (state_r == S_WRITE && req_r.cmd == CMD_INSERT && !found_r && !full) begin
      ord_we    = 1'b1;
      ord_wdata = count_r[AW-1:0];
    end
  end

  always_comb begin
    kv_we          = 1'b0;
    kv_waddr       = hit_slot_r;
    kv_wdata.key   = req_r.key;
    kv_wdata.value = req_r.value;
    if (state_r == S_WRITE) begin
      if (req_r.cmd == CMD_INSERT) begin
        if (found_r) begin
          kv_we = 1'b1;
        end else if (!full) begin
          kv_we    = 1'b1;
          kv_waddr = count_r[AW-1:0];
        end
      end else if (req_r.cmd == CMD_REKEY && found_r) begin
        kv_we          = 1'b1;
        kv_wdata.key   = req_r.new_key;
        kv_wdata.value = hit_val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      count_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r    <= req;
            rd_pos_r <= '0;
            v1_r     <= 1'b0;
            v2_r     <= 1'b0;
            found_r  <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          v1_r    <= issue;
          pos1_r  <= rd_pos_r[AW-1:0];
          v2_r    <= v1_r;
          pos2_r  <= pos1_r;
          slot2_r <= ord_rdata;
          if (issue) begin
            rd_pos_r <= rd_pos_r + CW'(1);
          end
          if (match) begin
            found_r    <= 1'b1;
            hit_slot_r <= slot2_r;
            hit_val_r  <= kv_rdata.value;
          end
          if (!issue && !v1_r && !v2_r) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          unique case (req_r.cmd)
            CMD_LOOKUP: begin
              rsp_r.status     <= found_r ? ST_OK : ST_MISS;
              rsp_r.read_value <= found_r ? hit_val_r : '1;
            end
            CMD_INSERT: begin
              rsp_r.status     <= (!found_r && full) ? ST_FULL : ST_OK;
              rsp_r.read_value <= '0;
              if (!found_r && !full) begin
                count_r <= count_r + CW'(1);
                bank_r  <= ~bank_r;
              end
            end
            CMD_REKEY: begin
              rsp_r.status     <= found_r ? ST_OK : ST_MISS;
              rsp_r.read_value <= '0;
              if (found_r) begin
                bank_r <= ~bank_r;
              end
            end
            default: begin
              rsp_r.status     <= ST_OK;
              rsp_r.read_value <= '0;
            end
          endcase
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/key_value_store_with_rekey_core.sv]
// Top level of the bounded key-value store with rekey.
`timescale 1ns / 1ps
// Usage:
//   Commands enter on the in_ channel (in_cmd, in_key, in_value, in_new_key) and each
//   produces exactly one result on the out_ channel (out_status, out_read_value).
//   A transfer happens on a rising edge where valid is high and stall is low.
//   Entries live in an entry memory (key and value per slot) and a recency memory of
//   two banks; every command scans the current bank front to back at one position per
//   cycle while rewriting the reordered list into the other bank.
//   The scan length grows with count, the number of stored entries (at most CAPACITY).
//   One command is in flight at a time; the recency scan through the two memories
//   is finished with before the next command is taken.
//   in_stall is high while a command is being worked on. A finished result waits in
//   the output register while the next command is taken; if the receiver stalls with
//   the output register full, the following result waits in the sequencer.
//   Reset (synchronous, active low) empties the table at once; no clearing pass.
module key_value_store_with_rekey_core #(
  parameter int CAPACITY = kvs_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_cmd,
  input  logic signed [kvs_pkg::DATA_W-1:0]  in_key,
  input  logic signed [kvs_pkg::DATA_W-1:0]  in_value,
  input  logic signed [kvs_pkg::DATA_W-1:0]  in_new_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic signed [kvs_pkg::DATA_W-1:0]  out_read_value
);

  import kvs_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  req_t     req;
  rsp_t     rsp;
  logic     seq_idle;
  logic     seq_done;
  logic     take;
  logic     start;

  logic          ord_we;
  logic [AW:0]   ord_waddr;
  logic [AW-1:0] ord_wdata;
  logic [AW:0]   ord_raddr;
  logic [AW-1:0] ord_rdata;
  logic          kv_we;
  logic [AW-1:0] kv_waddr;
  kv_word_t      kv_wdata;
  logic [AW-1:0] kv_raddr;
  kv_word_t      kv_rdata;

  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic signed [DATA_W-1:0] out_read_value_r;

  assign req.cmd     = in_cmd;
  assign req.key     = in_key;
  assign req.value   = in_value;
  assign req.new_key = in_new_key;

  assign in_stall = !seq_idle;
  assign start    = in_valid && seq_idle;
  assign take     = seq_done && (!out_valid_r || !out_stall);

  kvs_ram #(
    .DEPTH(2 << AW),
    .WIDTH(AW)
  ) u_order_ram (
    .clk  (clk),
    .we   (ord_we),
    .waddr(ord_waddr),
    .wdata(ord_wdata),
    .raddr(ord_raddr),
    .rdata(ord_rdata)
  );

  kvs_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(2 * DATA_W)
  ) u_entry_ram (
    .clk  (clk),
    .we   (kv_we),
    .waddr(kv_waddr),
    .wdata(kv_wdata),
    .raddr(kv_raddr),
    .rdata(kv_rdata)
  );

  kvs_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .idle     (seq_idle),
    .done     (seq_done),
    .take     (take),
    .rsp      (rsp),
    .ord_we   (ord_we),
    .ord_waddr(ord_waddr),
    .ord_wdata(ord_wdata),
    .ord_raddr(ord_raddr),
    .ord_rdata(ord_rdata),
    .kv_we    (kv_we),
    .kv_waddr (kv_waddr),
    .kv_wdata (kv_wdata),
    .kv_raddr (kv_raddr),
    .kv_rdata (kv_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r      <= 1'b1;
        out_status_r     <= rsp.status;
        out_read_value_r <= rsp.read_value;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;

  // An accepted command keeps the input side closed in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a transfer");

  // A new result only appears when the sequencer has handed one over.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(seq_done))
    else $error("result shown without a finished command");

  // A finished command with room in the output register is moved out at once.
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done && !(out_valid_r && out_stall) |=> out_valid_r && !seq_done)
    else $error("finished result not handed to the output register");

  // A miss on lookup always carries the all-ones value.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MISS && out_read_value != 0 |-> out_read_value == -1)
    else $error("miss reported with a wrong value");

endmodule

[tb/tb.sv]
// Self-checking testbench for the bounded key-value store with rekey.
`timescale 1ns / 1ps
module tb;
  import kvs_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int POOL_SIZE = 24;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = CAP + 40;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_LOOKUP;
  logic signed [DATA_W-1:0] in_key = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic signed [DATA_W-1:0] in_new_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [DATA_W-1:0] out_read_value;

  key_value_store_with_rekey_core #(.CAPACITY(CAP)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_key(in_key),
    .in_value(in_value),
    .in_new_key(in_new_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_read_value(out_read_value)
  );

  // Shadow copy of the table: slot contents and the recency list, newest first.
  logic signed [DATA_W-1:0] slot_key [CAP];
  logic signed [DATA_W-1:0] slot_val [CAP];
  int unsigned recency [CAP];
  int unsigned n_entries = 0;

  rsp_t pending_rsp [$];
  logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_sent = 0;
  int n_ok = 0;
  int n_miss = 0;
  int n_full = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Position in the recency list of the newest entry holding k, or n_entries.
  function automatic int unsigned find_newest(logic signed [DATA_W-1:0] k);
    int unsigned p;
    p = 0;
    while (p < n_entries && slot_key[recency[p]] != k) p++;
    return p;
  endfunction

  function automatic void bring_to_front(int unsigned p);
    int unsigned slot;
    slot = recency[p];
    for (int unsigned i = p; i > 0; i--) recency[i] = recency[i-1];
    recency[0] = slot;
  endfunction

  function automatic rsp_t predict_kvs(req_t r);
    rsp_t rsp;
    int unsigned p;
    int unsigned slot;
    logic hit;
    rsp.status = ST_OK;
    rsp.read_value = '0;
    p = find_newest(r.key);
    hit = (p < n_entries);
    case (r.cmd)
      CMD_LOOKUP: begin
        if (hit) begin
          rsp.read_value = slot_val[recency[p]];
        end else begin
          rsp.status = ST_MISS;
          rsp.read_value = '1;
        end
      end
      CMD_INSERT: begin
        if (hit) begin
          slot_val[recency[p]] = r.value;
        end else if (n_entries >= CAP) begin
          rsp.status = ST_FULL;
        end else begin
          slot = n_entries;
          slot_key[slot] = r.key;
          slot_val[slot] = r.value;
          recency[slot] = slot;
          n_entries++;
          bring_to_front(slot);
        end
      end
      CMD_REKEY: begin
        if (hit) begin
          slot_key[recency[p]] = r.new_key;
          bring_to_front(p);
        end else begin
          rsp.status = ST_MISS;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input logic [1:0] c, input logic signed [DATA_W-1:0] k,
                          input logic signed [DATA_W-1:0] v,
                          input logic signed [DATA_W-1:0] nk);
    req_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_key <= k;
    in_value <= v;
    in_new_key <= nk;
    do @(posedge clk); while (in_stall);
    r.cmd = c;
    r.key = k;
    r.value = v;
    r.new_key = nk;
    pending_rsp.push_back(predict_kvs(r));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_cmd();
    logic [1:0] c;
    logic signed [DATA_W-1:0] k;
    logic signed [DATA_W-1:0] nk;
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) c = CMD_LOOKUP;
    else if (sel < 70) c = CMD_INSERT;
    else if (sel < 95) c = CMD_REKEY;
    else c = CMD_UNUSED;
    // Mostly keys from a small pool so that hits, updates and shadowing are common.
    k = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE-1)];
    nk = ($urandom_range(4) == 0) ? $urandom : key_pool[$urandom_range(POOL_SIZE-1)];
    send_cmd(c, k, $urandom, nk);
  endtask

  task automatic test_directed();
    send_cmd(CMD_LOOKUP, 32'sd5, '0, '0);
    send_cmd(CMD_REKEY, 32'sd5, '0, 32'sd6);
    send_cmd(CMD_UNUSED, KEY_MAX, KEY_MIN, '1);
    send_cmd(CMD_INSERT, KEY_MIN, KEY_MAX, '0);
    send_cmd(CMD_INSERT, KEY_MAX, KEY_MIN, '0);
    send_cmd(CMD_INSERT, 32'sd0, 32'sd0, '0);
    send_cmd(CMD_INSERT, -32'sd1, -32'sd1, '0);
    send_cmd(CMD_LOOKUP, KEY_MIN, '0, '0);
    send_cmd(CMD_LOOKUP, KEY_MAX, '0, '0);
    send_cmd(CMD_LOOKUP, 32'sd0, '0, '0);
    send_cmd(CMD_LOOKUP, -32'sd1, '0, '0);
    send_cmd(CMD_INSERT, KEY_MIN, 32'sd77, '0);
    send_cmd(CMD_LOOKUP, KEY_MIN, '0, '0);
    // Renaming onto a key that already exists shadows the older entry.
    send_cmd(CMD_REKEY, KEY_MAX, '1, 32'sd0);
    send_cmd(CMD_LOOKUP, 32'sd0, '0, '0);
    send_cmd(CMD_LOOKUP, KEY_MAX, '0, '0);
    send_cmd(CMD_REKEY, -32'sd1, '0, -32'sd1);
    send_cmd(CMD_LOOKUP, -32'sd1, '0, '0);
    send_cmd(CMD_REKEY, 32'sd12345, '0, KEY_MAX);
    send_cmd(CMD_UNUSED, 32'sd0, '1, KEY_MIN);
    send_cmd(CMD_LOOKUP, 32'sd0, '0, '0);
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random_cmd();
  endtask

  task automatic test_full_table();
    logic signed [DATA_W-1:0] k;
    send_idle_pct = 0;
    recv_stall_pct = 22;
    while (n_entries < CAP) send_cmd(CMD_INSERT, $urandom, $urandom, '0);
    do k = $urandom; while (find_newest(k) < n_entries);
    send_cmd(CMD_INSERT, k, $urandom, '0);
    send_cmd(CMD_LOOKUP, k, '0, '0);
    // The oldest entry can still be updated and renamed once the table is full.
    k = slot_key[recency[CAP-1]];
    send_cmd(CMD_INSERT, k, KEY_MIN, '0);
    send_cmd(CMD_LOOKUP, k, '0, '0);
    send_cmd(CMD_REKEY, k, '0, KEY_MAX);
    send_cmd(CMD_LOOKUP, KEY_MAX, '0, '0);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      case (out_status)
        ST_OK: n_ok++;
        ST_MISS: n_miss++;
        default: n_full++;
      endcase
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: status %0d read_value %0d", out_status, out_read_value);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_status);
          errors++;
        end
        if (out_read_value !== exp_rsp.read_value) begin
          $error("read_value: expected %0d, got %0d", exp_rsp.read_value, out_read_value);
          errors++;
        end
      end
    end
  end

  // Ends the run if neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    key_pool[4] = 32'sd1;
    for (int i = 5; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 76, 0);
    test_random_traffic(250, 0, 76);
    test_random_traffic(250, 22, 22);
    test_full_table();
    test_random_traffic(100, 0, 0);
    test_random_traffic(100, 76, 0);
    test_random_traffic(100, 0, 76);
    test_random_traffic(100, 22, 22);
    in_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d results never arrived", pending_rsp.size());
      errors++;
    end

    $display("Sent %0d commands over four idling patterns, with the table filled to %0d.",
             n_sent, n_entries);
    $display("Results seen: %0d ok/found, %0d not found, %0d full; %0d mismatches.",
             n_ok, n_miss, n_full, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
